[hdl/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types, constants and the control store of the line discipline
// sequencer.
// ----------------------------------------------------------------------------
package tle_pkg;

    // Ring buffer geometry.
    localparam int BUFFER_DEPTH = 64;
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    // Microprogram address width.
    localparam int UA_W = 6;

    // Character codes.
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_CARET = 8'd94;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_BSL   = 8'd92;
    localparam logic [7:0] CH_FS    = 8'd28;
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] CARET_OFFSET = 8'd64;

    // Configuration register indexes.
    localparam logic REG_ECHO_ENABLE = 1'b0;
    localparam logic REG_LINE_ENABLE = 1'b1;

    // Input action codes.
    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    typedef enum logic [1:0] {
        KIND_ECHO      = 2'd0,
        KIND_DATA      = 2'd1,
        KIND_NOT_READY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_STORE,
        OP_RD_HEAD,
        OP_RD_TAIL,
        OP_POP,
        OP_ERASE,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        CND_NEXT,
        CND_ALWAYS,
        CND_IS_READ,
        CND_RAW,
        CND_IS_ERASE,
        CND_CARET,
        CND_NOT_READY,
        CND_EMPTY,
        CND_RD_NL,
        CND_RD_CTRL
    } cond_t;

    typedef enum logic [2:0] {
        SRC_CHAR,
        SRC_CARET,
        SRC_CARET2,
        SRC_DATA,
        SRC_ZERO,
        SRC_BS,
        SRC_SP
    } src_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [UA_W-1:0] target;
        src_t            src;
        kind_t           kind;
        logic            last;
    } uword_t;

    // Microprogram entry points.
    localparam logic [UA_W-1:0] UA_FETCH   = 6'd0;
    localparam logic [UA_W-1:0] UA_CARET   = 6'd7;
    localparam logic [UA_W-1:0] UA_READ    = 6'd10;
    localparam logic [UA_W-1:0] UA_NREADY  = 6'd14;
    localparam logic [UA_W-1:0] UA_RAW     = 6'd20;
    localparam logic [UA_W-1:0] UA_ERASE   = 6'd30;
    localparam logic [UA_W-1:0] UA_WIDE_RB = 6'd37;

    function automatic uword_t uw(op_t op, cond_t cond, logic [UA_W-1:0] target,
                                  src_t src, kind_t kind, logic last);
        uword_t w;
        w.op = op;
        w.cond = cond;
        w.target = target;
        w.src = src;
        w.kind = kind;
        w.last = last;
        return w;
    endfunction

    // Control store. Each word names one datapath action and an optional
    // branch evaluated on the state as it stands at that step.
    function automatic uword_t ucode_rom(logic [UA_W-1:0] ua);
        uword_t w;
        w = uw(OP_NOP, CND_ALWAYS, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
        unique case (ua)
            // Dispatch.
            6'd0:  w = uw(OP_ACCEPT, CND_NEXT, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd1:  w = uw(OP_NOP, CND_IS_READ, UA_READ, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd2:  w = uw(OP_NOP, CND_RAW, UA_RAW, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd3:  w = uw(OP_NOP, CND_IS_ERASE, UA_ERASE, SRC_ZERO, KIND_ECHO, 1'b0);
            // Echo and store.
            6'd4:  w = uw(OP_STORE, CND_NEXT, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd5:  w = uw(OP_NOP, CND_CARET, UA_CARET, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd6:  w = uw(OP_EMIT, CND_ALWAYS, UA_FETCH, SRC_CHAR, KIND_ECHO, 1'b1);
            6'd7:  w = uw(OP_EMIT, CND_NEXT, UA_FETCH, SRC_CARET, KIND_ECHO, 1'b0);
            6'd8:  w = uw(OP_EMIT, CND_ALWAYS, UA_FETCH, SRC_CARET2, KIND_ECHO, 1'b1);
            // Read.
            6'd10: w = uw(OP_NOP, CND_NOT_READY, UA_NREADY, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd11: w = uw(OP_RD_HEAD, CND_NEXT, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd12: w = uw(OP_POP, CND_NEXT, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd13: w = uw(OP_EMIT, CND_ALWAYS, UA_FETCH, SRC_DATA, KIND_DATA, 1'b1);
            6'd14: w = uw(OP_EMIT, CND_ALWAYS, UA_FETCH, SRC_ZERO, KIND_NOT_READY, 1'b1);
            // Raw store.
            6'd20: w = uw(OP_STORE, CND_ALWAYS, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
            // Erase.
            6'd30: w = uw(OP_NOP, CND_EMPTY, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd31: w = uw(OP_RD_TAIL, CND_NEXT, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd32: w = uw(OP_NOP, CND_RD_NL, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd33: w = uw(OP_ERASE, CND_RD_CTRL, UA_WIDE_RB, SRC_ZERO, KIND_ECHO, 1'b0);
            6'd34: w = uw(OP_EMIT, CND_NEXT, UA_FETCH, SRC_BS, KIND_ECHO, 1'b0);
            6'd35: w = uw(OP_EMIT, CND_NEXT, UA_FETCH, SRC_SP, KIND_ECHO, 1'b0);
            6'd36: w = uw(OP_EMIT, CND_ALWAYS, UA_FETCH, SRC_BS, KIND_ECHO, 1'b1);
            6'd37: w = uw(OP_EMIT, CND_NEXT, UA_FETCH, SRC_BS, KIND_ECHO, 1'b0);
            6'd38: w = uw(OP_EMIT, CND_NEXT, UA_FETCH, SRC_BS, KIND_ECHO, 1'b0);
            6'd39: w = uw(OP_EMIT, CND_NEXT, UA_FETCH, SRC_SP, KIND_ECHO, 1'b0);
            6'd40: w = uw(OP_EMIT, CND_NEXT, UA_FETCH, SRC_SP, KIND_ECHO, 1'b0);
            6'd41: w = uw(OP_EMIT, CND_NEXT, UA_FETCH, SRC_BS, KIND_ECHO, 1'b0);
            6'd42: w = uw(OP_EMIT, CND_ALWAYS, UA_FETCH, SRC_BS, KIND_ECHO, 1'b1);
            default: w = uw(OP_NOP, CND_ALWAYS, UA_FETCH, SRC_ZERO, KIND_ECHO, 1'b0);
        endcase
        return w;
    endfunction

endpackage

[hdl/tty_line_edit_echo_buffer.sv]
// One transaction at a time: a new one is accepted only when the microprogram is back
// at its accept step. The sequencer steps one control word per cycle, except that it
// waits there for input and holds an emit step while the last result is not taken.
// A raw store and an erase that changes nothing give no result.
// Reset (aresetn low, synchronous) empties the buffer and sets echo and line mode to 1.
// ----------------------------------------------------------------------------
// tty_line_edit_echo_buffer
// Canonical terminal line discipline: a microcoded sequencer drives a ring
// buffer, an echo generator and a one-entry result register.
// ----------------------------------------------------------------------------
module tty_line_edit_echo_buffer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_wdata,
    // Input channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_rx_byte,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic        m_input_available
);
    import tle_pkg::*;

    // Sequencer state.
    logic [UA_W-1:0] upc_reg, upc_next;
    uword_t          uword;
    logic            cond_true;
    logic            stall;

    // Configuration registers.
    logic echo_enable_reg;
    logic line_enable_reg;

    // Latched transaction. The character is stored already mapped, so a
    // carriage return is a newline from here on.
    logic       action_reg;
    logic [7:0] char_reg;

    // Ring buffer control.
    logic [AW-1:0] write_index_reg;
    logic [AW-1:0] read_index_reg;
    logic [CW-1:0] fill_count_reg;
    logic [CW-1:0] newline_count_reg;
    logic [AW-1:0] write_prev;
    logic [AW-1:0] write_succ;
    logic [AW-1:0] read_succ;
    logic          buf_full;
    logic          buf_empty;
    logic          input_avail;

    // Line storage with a registered read port.
    logic [7:0] line_store [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;
    logic       mem_wr;
    logic       mem_rd;
    logic [AW-1:0] mem_rd_addr;

    // Result register.
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_avail_reg;
    logic [7:0] emit_byte;
    logic       do_emit;
    logic       is_ctrl;

    assign uword = ucode_rom(upc_reg);

    // Besides waiting for input at the accept step, the sequencer only waits on an emit
    // step while the result register still holds a result that the consumer has not taken.
    assign stall   = (uword.op == OP_EMIT) && out_valid_reg && !m_ready;
    assign do_emit = (uword.op == OP_EMIT) && !stall;
    assign s_ready = (uword.op == OP_ACCEPT);

    // Ring arithmetic.
    assign write_succ = (write_index_reg == AW'(BUFFER_DEPTH - 1)) ? '0
                                                                    : write_index_reg + 1'b1;
    assign write_prev = (write_index_reg == '0) ? AW'(BUFFER_DEPTH - 1)
                                                : write_index_reg - 1'b1;
    assign read_succ  = (read_index_reg == AW'(BUFFER_DEPTH - 1)) ? '0
                                                                  : read_index_reg + 1'b1;
    assign buf_full   = (fill_count_reg == CW'(BUFFER_DEPTH));
    assign buf_empty  = (fill_count_reg == '0);

    // Availability always reflects the state after the transaction, because
    // every buffer update in the microprogram comes before its first emit.
    assign input_avail = line_enable_reg ? (newline_count_reg != '0) : !buf_empty;

    assign is_ctrl = (char_reg < CTRL_LIMIT);

    // Branch conditions.
    always_comb begin
        unique case (uword.cond)
            CND_NEXT:      cond_true = 1'b0;
            CND_ALWAYS:    cond_true = 1'b1;
            CND_IS_READ:   cond_true = (action_reg == ACT_READ);
            CND_RAW:       cond_true = !echo_enable_reg;
            CND_IS_ERASE:  cond_true = (char_reg == CH_BS) || (char_reg == CH_DEL);
            CND_CARET:     cond_true = is_ctrl && (char_reg != CH_NL);
            CND_NOT_READY: cond_true = (newline_count_reg == '0) || buf_empty;
            CND_EMPTY:     cond_true = buf_empty;
            CND_RD_NL:     cond_true = (rd_data_reg == CH_NL);
            CND_RD_CTRL:   cond_true = (rd_data_reg < CTRL_LIMIT);
            default:       cond_true = 1'b0;
        endcase
    end

    // Next microprogram address: the accept step holds until a transaction
    // arrives, an emit step holds while the output is blocked.
    always_comb begin
        upc_next = upc_reg;
        if (uword.op == OP_ACCEPT) begin
            if (s_valid) begin
                upc_next = upc_reg + 1'b1;
            end
        end else if (!stall) begin
            upc_next = cond_true ? uword.target : upc_reg + 1'b1;
        end
    end

    // Echo character selection. The second character of a caret pair is
    // the code plus 64, except that NUL shows as a zero digit and the file
    // separator as a backslash.
    always_comb begin
        unique case (uword.src)
            SRC_CHAR:  emit_byte = char_reg;
            SRC_CARET: emit_byte = CH_CARET;
            SRC_CARET2: begin
                if (char_reg == CH_NUL) begin
                    emit_byte = CH_ZERO;
                end else if (char_reg == CH_FS) begin
                    emit_byte = CH_BSL;
                end else begin
                    emit_byte = char_reg + CARET_OFFSET;
                end
            end
            SRC_DATA:  emit_byte = rd_data_reg;
            SRC_ZERO:  emit_byte = 8'd0;
            SRC_BS:    emit_byte = CH_BS;
            SRC_SP:    emit_byte = CH_SP;
            default:   emit_byte = 8'd0;
        endcase
    end

    // A store into a full buffer is silently dropped.
    assign mem_wr      = (uword.op == OP_STORE) && !buf_full;
    assign mem_rd      = (uword.op == OP_RD_HEAD) || (uword.op == OP_RD_TAIL);
    assign mem_rd_addr = (uword.op == OP_RD_HEAD) ? read_index_reg : write_prev;

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            line_store[write_index_reg] <= char_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            rd_data_reg <= line_store[mem_rd_addr];
        end
    end

    // Sequencer, configuration and buffer bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg           <= UA_FETCH;
            echo_enable_reg   <= 1'b1;
            line_enable_reg   <= 1'b1;
            write_index_reg   <= '0;
            read_index_reg    <= '0;
            fill_count_reg    <= '0;
            newline_count_reg <= '0;
        end else begin
            upc_reg <= upc_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ECHO_ENABLE: echo_enable_reg <= cfg_wdata;
                    REG_LINE_ENABLE: line_enable_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (mem_wr) begin
                write_index_reg <= write_succ;
                fill_count_reg  <= fill_count_reg + 1'b1;
                if (char_reg == CH_NL) begin
                    newline_count_reg <= newline_count_reg + 1'b1;
                end
            end
            if (uword.op == OP_POP) begin
                read_index_reg <= read_succ;
                fill_count_reg <= fill_count_reg - 1'b1;
                if (rd_data_reg == CH_NL) begin
                    newline_count_reg <= newline_count_reg - 1'b1;
                end
            end
            if (uword.op == OP_ERASE) begin
                write_index_reg <= write_prev;
                fill_count_reg  <= fill_count_reg - 1'b1;
            end
        end
    end

    // Transaction capture; carriage return becomes newline here.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            char_reg   <= (s_rx_byte == CH_CR) ? CH_NL : s_rx_byte;
        end
    end

    // Result register: valid is control, the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (do_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            out_kind_reg  <= uword.kind;
            out_byte_reg  <= emit_byte;
            out_last_reg  <= uword.last;
            out_avail_reg <= input_avail;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_kind            = out_kind_reg;
    assign m_out_byte        = out_byte_reg;
    assign m_last            = out_last_reg;
    assign m_input_available = out_avail_reg;

endmodule

[bench/tty_line_edit_echo_buffer_test.sv]
// ----------------------------------------------------------------------------
// tty_line_edit_echo_buffer_test
// Self-checking bench for the terminal line discipline. A software copy of
// the ring buffer predicts echo, read and not-ready results for each input
// transaction. Both channels idle and stall at random over several register
// settings.
// ----------------------------------------------------------------------------
module tty_line_edit_echo_buffer_test;
    import tle_pkg::*;

class line_echo_scoreboard;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
        logic       avail;
    } echo_result_t;

    // Shadow of the line buffer and of the two mode registers.
    logic [7:0]   ring [BUFFER_DEPTH];
    int           wr_pos;
    int           rd_pos;
    int           held;
    int           newlines;
    bit           echo_on;
    bit           line_on;

    echo_result_t expected_results[$];

    int           errors;
    int           inputs_seen;
    int           results_seen;
    int           echo_seen;
    int           data_seen;
    int           not_ready_seen;
    int           bytes_dropped;
    int           erase_wide;
    int           erase_narrow;

    function new();
        wr_pos = 0;
        rd_pos = 0;
        held = 0;
        newlines = 0;
        echo_on = 1'b1;
        line_on = 1'b1;
        errors = 0;
        inputs_seen = 0;
        results_seen = 0;
        echo_seen = 0;
        data_seen = 0;
        not_ready_seen = 0;
        bytes_dropped = 0;
        erase_wide = 0;
        erase_narrow = 0;
    endfunction

    function void configure(bit echo, bit line);
        echo_on = echo;
        line_on = line;
    endfunction

    function void buffer_char(logic [7:0] c);
        if (held >= BUFFER_DEPTH) begin
            bytes_dropped++;
            return;
        end
        ring[wr_pos] = c;
        wr_pos = (wr_pos + 1) % BUFFER_DEPTH;
        held++;
        if (c == CH_NL)
            newlines++;
    endfunction

    // Works out the results that one accepted input transaction causes.
    function void predict_from_input(logic act, logic [7:0] rx);
        logic [7:0]   chars[$];
        logic [7:0]   c;
        logic [7:0]   tail;
        kind_t        kind;
        echo_result_t r;
        int           prev;
        inputs_seen++;
        kind = KIND_ECHO;
        c = rx;
        if (act == ACT_READ) begin
            if (newlines != 0 && held != 0) begin
                tail = ring[rd_pos];
                rd_pos = (rd_pos + 1) % BUFFER_DEPTH;
                held--;
                if (tail == CH_NL)
                    newlines--;
                kind = KIND_DATA;
                chars.push_back(tail);
            end else begin
                kind = KIND_NOT_READY;
                chars.push_back(8'd0);
            end
        end else begin
            if (c == CH_CR)
                c = CH_NL;
            if (!echo_on) begin
                buffer_char(c);
            end else if (c == CH_BS || c == CH_DEL) begin
                if (held != 0) begin
                    prev = (wr_pos + BUFFER_DEPTH - 1) % BUFFER_DEPTH;
                    tail = ring[prev];
                    if (tail != CH_NL) begin
                        wr_pos = prev;
                        held--;
                        if (tail < CTRL_LIMIT) begin
                            erase_wide++;
                            chars = '{CH_BS, CH_BS, CH_SP, CH_SP, CH_BS, CH_BS};
                        end else begin
                            erase_narrow++;
                            chars = '{CH_BS, CH_SP, CH_BS};
                        end
                    end
                end
            end else begin
                if (c == CH_NL)
                    chars.push_back(CH_NL);
                else if (c == CH_NUL)
                    chars = '{CH_CARET, CH_ZERO};
                else if (c == CH_FS)
                    chars = '{CH_CARET, CH_BSL};
                else if (c < CTRL_LIMIT)
                    chars = '{CH_CARET, c + CARET_OFFSET};
                else
                    chars.push_back(c);
                buffer_char(c);
            end
        end
        foreach (chars[i]) begin
            r.kind = kind;
            r.data = chars[i];
            r.last = (i == chars.size() - 1);
            r.avail = line_on ? (newlines != 0) : (held != 0);
            expected_results.push_back(r);
        end
    endfunction

    task report(string what);
        if (errors < 40)
            $display("MISMATCH: %s", what);
        errors++;
    endtask

    task check_result(logic [1:0] kind, logic [7:0] data, logic last, logic avail);
        echo_result_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report($sformatf("result kind %0d byte 0x%02h with nothing expected",
                             kind, data));
            return;
        end
        want = expected_results.pop_front();
        case (want.kind)
            KIND_ECHO:      echo_seen++;
            KIND_DATA:      data_seen++;
            default:        not_ready_seen++;
        endcase
        if (kind !== want.kind)
            report($sformatf("result %0d: kind %0d, wanted %0d", results_seen, kind,
                             want.kind));
        if (data !== want.data)
            report($sformatf("result %0d: byte 0x%02h, wanted 0x%02h", results_seen,
                             data, want.data));
        if (last !== want.last)
            report($sformatf("result %0d: last %b, wanted %b", results_seen, last,
                             want.last));
        if (avail !== want.avail)
            report($sformatf("result %0d: input_available %b, wanted %b", results_seen,
                             avail, want.avail));
    endtask

    task close_out();
        if (expected_results.size() != 0)
            report($sformatf("%0d expected results never arrived",
                             expected_results.size()));
    endtask

endclass

    // This margin covers a transaction that ends without any result while the
    // block is still busy.
    localparam int DRAIN_CYCLES   = 40;
    // Cycles in which no transaction moves on either channel before giving up.
    localparam int WATCHDOG_LIMIT = 5000;
    // Length of the forced hold-off on the result channel.
    localparam int HOLD_CYCLES    = 400;
    // Register settings per random phase, bit p belongs to phase p.
    localparam logic [7:0] PHASE_ECHO = 8'b1011_0101;
    localparam logic [7:0] PHASE_LINE = 8'b1101_0011;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = REG_ECHO_ENABLE;
    logic       cfg_wdata = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_action = ACT_RECEIVE;
    logic [7:0] s_rx_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       m_input_available;

    line_echo_scoreboard sb;

    // Idle controls. The sender percentage is only used by the stimulus
    // process; the receiver percentage and the hold-off token cross to the
    // receiver process through nonblocking writes.
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic [7:0]  hold_token = 8'd0;
    logic [7:0]  hold_seen = 8'd0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          settings_count = 0;

    tty_line_edit_echo_buffer u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_out_byte        (m_out_byte),
        .m_last            (m_last),
        .m_input_available (m_input_available)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result channel ready. A new hold-off token starts a long stretch with
    // ready low, so the single in-flight transaction cannot retire and the
    // input side backs up. Otherwise ready follows the stall percentage.
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor. Handshakes are sampled at the edge with the values that held
    // before it, so every accepted transaction is seen exactly once. The
    // watchdog sits at the end and counts cycles with no transaction at all.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.predict_from_input(s_action, s_rx_byte);
            if (m_valid && m_ready)
                sb.check_result(m_kind, m_out_byte, m_last, m_input_available);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offers one input transaction and returns at the edge that accepts it.
    // Valid is left high on return; the next call either lowers it for an
    // idle cycle or replaces the payload, so valid never dips between two
    // back-to-back transactions.
    task automatic send_item(input logic act, input logic [7:0] rx);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Stops offering and waits until every predicted result has come back,
    // then lets the block finish any transaction that ends without a result.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes both mode registers while the block is idle.
    task automatic set_mode(input bit echo, input bit line);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ECHO_ENABLE;
        cfg_wdata <= echo;
        @(posedge aclk);
        cfg_index <= REG_LINE_ENABLE;
        cfg_wdata <= line;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.configure(echo, line);
        settings_count++;
    endtask

    // Empties the buffer so that a full buffer with no newline cannot block
    // later phases. Erase needs echo mode, so raw mode is left first. Each
    // step waits for the block to go idle so the shadow state is settled.
    task automatic empty_buffer();
        wait_drained();
        if (!sb.echo_on)
            set_mode(1'b1, sb.line_on);
        while (sb.held != 0) begin
            if (sb.newlines != 0)
                send_item(ACT_READ, 8'($urandom_range(255)));
            else if (sb.held == BUFFER_DEPTH)
                send_item(ACT_RECEIVE, CH_BS);
            else
                send_item(ACT_RECEIVE, CH_CR);
            wait_drained();
        end
    endtask

    // One typed character: mostly printable, some high codes, some control
    // codes, and a share of backspace and DEL edits.
    function automatic logic [7:0] line_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 8'($urandom_range(126, 32));
        if (r < 70)
            return 8'($urandom_range(255, 128));
        if (r < 85)
            return 8'($urandom_range(31, 0));
        return $urandom_range(1) ? CH_BS : CH_DEL;
    endfunction

    // Random traffic shaped like terminal use: a line of characters, usually
    // closed by a newline or carriage return, then reads that drain it and
    // run a little past the end. Now and then a line is long enough to
    // overflow the buffer, and a short burst of arbitrary transactions mixes
    // in as noise.
    task automatic random_traffic(input int budget);
        int sent;
        int len;
        int reads;
        int k;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(72, 40) : $urandom_range(12);
            for (k = 0; k < len; k++)
                send_item(ACT_RECEIVE, line_char());
            if ($urandom_range(9) != 0) begin
                send_item(ACT_RECEIVE, $urandom_range(1) ? CH_NL : CH_CR);
                sent++;
            end
            reads = len + $urandom_range(3);
            for (k = 0; k < reads; k++)
                send_item(ACT_READ, 8'($urandom_range(255)));
            sent += len + reads;
            if ($urandom_range(3) == 0) begin
                reads = $urandom_range(3, 1);
                for (k = 0; k < reads; k++)
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
                sent += reads;
            end
        end
    endtask

    initial begin
        int p;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part in the reset mode (echo and line mode on). It starts
        // with a read and an erase on the empty buffer, then the caret
        // spellings, the code-28 and NUL forms, codes 32, 128 and 255, both
        // erase widths, a carriage return and an erase that hits a newline.
        send_item(ACT_READ, 8'hFF);
        send_item(ACT_RECEIVE, CH_BS);
        send_item(ACT_RECEIVE, CH_NUL);
        send_item(ACT_RECEIVE, CH_FS);
        send_item(ACT_RECEIVE, 8'd1);
        send_item(ACT_RECEIVE, 8'd31);
        send_item(ACT_RECEIVE, CH_SP);
        send_item(ACT_RECEIVE, 8'd255);
        send_item(ACT_RECEIVE, 8'd128);
        send_item(ACT_RECEIVE, CH_DEL);
        send_item(ACT_RECEIVE, CH_BS);
        send_item(ACT_RECEIVE, CH_BS);
        send_item(ACT_RECEIVE, CH_BS);
        send_item(ACT_RECEIVE, CH_CR);
        send_item(ACT_RECEIVE, CH_BS);
        repeat (5) send_item(ACT_READ, 8'h00);

        // Raw mode stores edit characters and a carriage return as data and
        // gives no echo at all.
        set_mode(1'b0, 1'b1);
        send_item(ACT_RECEIVE, CH_BS);
        send_item(ACT_RECEIVE, CH_DEL);
        send_item(ACT_RECEIVE, 8'd65);
        send_item(ACT_RECEIVE, CH_CR);
        send_item(ACT_READ, 8'hA5);

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering a line that overflows the buffer, so the
        // block stalls its input and later drops bytes on a full buffer.
        set_mode(1'b1, 1'b1);
        sender_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_token <= hold_token + 8'd1;
        repeat (70) send_item(ACT_RECEIVE, 8'($urandom_range(126, 33)));
        empty_buffer();

        // Random phases over all four register combinations, each with its
        // own idle pattern: none, sender, receiver, then both.
        for (p = 0; p < 8; p++) begin
            set_mode(PHASE_ECHO[p], PHASE_LINE[p]);
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    sender_idle_pct = 78;
                    recv_stall_pct <= 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct <= 78;
                end
                default: begin
                    sender_idle_pct = 17;
                    recv_stall_pct <= 17;
                end
            endcase
            random_traffic(30);
            empty_buffer();
        end

        wait_drained();
        sb.close_out();
        $display("Covered %0d inputs, %0d results: %0d echo, %0d data, %0d not ready.",
                 sb.inputs_seen, sb.results_seen, sb.echo_seen, sb.data_seen,
                 sb.not_ready_seen);
        $display("Settings %0d, dropped when full %0d, erases %0d wide, %0d narrow.",
                 settings_count, sb.bytes_dropped, sb.erase_wide, sb.erase_narrow);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
hdl/tle_pkg.sv
hdl/tty_line_edit_echo_buffer.sv
bench/tty_line_edit_echo_buffer_test.sv
